/* src/btod_pkg.sv */
`default_nettype none

package btod_pkg;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_RESET = 2'd1,
        MODE_SET   = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    localparam logic [3:0] MAX_UNITS       = 4'd9;
    localparam logic [3:0] MAX_MINSEC_TENS = 4'd5;
    localparam logic [3:0] MAX_HOUR_TENS   = 4'd2;
    localparam logic [3:0] MAX_HOUR_UNITS_AT_TOP = 4'd3;

    typedef struct packed {
        mode_t      mode;
        logic [3:0] set_hour_tens;
        logic [3:0] set_hour_units;
        logic [3:0] set_minute_tens;
        logic [3:0] set_minute_units;
        logic [3:0] set_second_tens;
        logic [3:0] set_second_units;
    } in_item_t;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [2:0] second_tens;
        logic [3:0] second_units;
    } out_item_t;

endpackage

`default_nettype wire

/* src/bcd_time_of_day_clock.sv */
// 24-hour hh:mm:ss clock kept as six BCD digits plus a run flag. Each item is a
// command: tick, reset-and-run, set-and-run or stop. Reset, set and a tick while
// running each return one item with the digits now held; stop and a tick while
// stopped return nothing. A set pair that is out of range (hours above 23,
// minutes or seconds above 59, or a digit above 9) loads as 00. The block takes
// one item per cycle unless a result must wait on a stalled output register: a
// command is held in the input register, where the digit compare and carry logic
// updates the time, and its result is then held in the output register. After
// reset the time is 00:00:00 and the clock is stopped.
`default_nettype none

module bcd_time_of_day_clock (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire btod_pkg::in_item_t in_item,
    output logic               out_valid,
    input  wire                out_ready,
    output btod_pkg::out_item_t out_item
);

    logic                s1_valid_reg;
    btod_pkg::in_item_t  s1_item_reg;
    logic                out_valid_reg;
    btod_pkg::out_item_t out_item_reg;
    btod_pkg::out_item_t time_reg;
    btod_pkg::out_item_t time_next;
    logic                running_reg;
    logic                running_next;
    logic                emit;
    logic                s1_fire;
    logic                out_free;
    logic                hour_ok;
    logic                minute_ok;
    logic                second_ok;
    logic                sec_wrap;
    logic                sec_tens_wrap;
    logic                min_wrap;
    logic                min_tens_wrap;

    // set range checks
    always_comb
    begin
        hour_ok = (s1_item_reg.set_hour_units <= btod_pkg::MAX_UNITS)
               && ((s1_item_reg.set_hour_tens < btod_pkg::MAX_HOUR_TENS)
               || ((s1_item_reg.set_hour_tens == btod_pkg::MAX_HOUR_TENS)
               && (s1_item_reg.set_hour_units <= btod_pkg::MAX_HOUR_UNITS_AT_TOP)));
        minute_ok = (s1_item_reg.set_minute_tens <= btod_pkg::MAX_MINSEC_TENS)
                 && (s1_item_reg.set_minute_units <= btod_pkg::MAX_UNITS);
        second_ok = (s1_item_reg.set_second_tens <= btod_pkg::MAX_MINSEC_TENS)
                 && (s1_item_reg.set_second_units <= btod_pkg::MAX_UNITS);
    end

    // carry chain for one second
    always_comb
    begin
        sec_wrap      = (time_reg.second_units == btod_pkg::MAX_UNITS);
        sec_tens_wrap = sec_wrap && (time_reg.second_tens == btod_pkg::MAX_MINSEC_TENS[2:0]);
        min_wrap      = sec_tens_wrap && (time_reg.minute_units == btod_pkg::MAX_UNITS);
        min_tens_wrap = min_wrap && (time_reg.minute_tens == btod_pkg::MAX_MINSEC_TENS[2:0]);
    end

    always_comb
    begin
        time_next    = time_reg;
        running_next = running_reg;
        emit         = 1'b0;
        case (s1_item_reg.mode)
            btod_pkg::MODE_RESET:
            begin
                time_next    = '0;
                running_next = 1'b1;
                emit         = 1'b1;
            end
            btod_pkg::MODE_SET:
            begin
                time_next = '0;
                if (hour_ok)
                begin
                    time_next.hour_tens  = s1_item_reg.set_hour_tens[1:0];
                    time_next.hour_units = s1_item_reg.set_hour_units;
                end
                if (minute_ok)
                begin
                    time_next.minute_tens  = s1_item_reg.set_minute_tens[2:0];
                    time_next.minute_units = s1_item_reg.set_minute_units;
                end
                if (second_ok)
                begin
                    time_next.second_tens  = s1_item_reg.set_second_tens[2:0];
                    time_next.second_units = s1_item_reg.set_second_units;
                end
                running_next = 1'b1;
                emit         = 1'b1;
            end
            btod_pkg::MODE_STOP:
            begin
                running_next = 1'b0;
            end
            default:
            begin
                if (running_reg)
                begin
                    emit = 1'b1;
                    time_next.second_units = sec_wrap ? 4'd0 : time_reg.second_units + 4'd1;
                    if (sec_wrap)
                        time_next.second_tens = sec_tens_wrap ? 3'd0
                                              : time_reg.second_tens + 3'd1;
                    if (sec_tens_wrap)
                        time_next.minute_units = min_wrap ? 4'd0
                                               : time_reg.minute_units + 4'd1;
                    if (min_wrap)
                        time_next.minute_tens = min_tens_wrap ? 3'd0
                                              : time_reg.minute_tens + 3'd1;
                    if (min_tens_wrap)
                    begin
                        if ((time_reg.hour_tens == btod_pkg::MAX_HOUR_TENS[1:0])
                            && (time_reg.hour_units == btod_pkg::MAX_HOUR_UNITS_AT_TOP))
                        begin
                            time_next.hour_tens  = 2'd0;
                            time_next.hour_units = 4'd0;
                        end
                        else if (time_reg.hour_units == btod_pkg::MAX_UNITS)
                        begin
                            time_next.hour_tens  = time_reg.hour_tens + 2'd1;
                            time_next.hour_units = 4'd0;
                        end
                        else
                        begin
                            time_next.hour_units = time_reg.hour_units + 4'd1;
                        end
                    end
                end
            end
        endcase
    end

    // an item with no result never waits on the output side
    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (out_free || !emit);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            time_reg      <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_fire)
            begin
                time_reg    <= time_next;
                running_reg <= running_next;
            end
            if (s1_fire && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_item_reg <= in_item;
        if (s1_fire && emit)
            out_item_reg <= time_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import btod_pkg::*;

    localparam int RANDOM_ITEMS   = 900;
    localparam int QUIET_TAIL     = 150;
    localparam int DRAIN_EVERY    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam int TOP_HOURS      = 23;
    localparam int TOP_MINSEC     = 59;

    typedef struct {
        in_item_t  cmd;
        bit        typed;
        bit        gives;
        out_item_t want;
    } step_row_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // hand-typed expectation travelling alongside the item on the wire
    bit        row_typed = 1'b0;
    bit        row_gives = 1'b0;
    out_item_t row_want  = '0;

    int gap_pct     = 0;
    int stall_pct   = 0;
    int stall_left  = 0;
    int fail_count  = 0;
    int n_results   = 0;
    int n_wraps     = 0;
    int n_cleared   = 0;
    int idle_cycles = 0;

    out_item_t pending_faces[$];

    // predicted clock state
    logic [1:0] held_ht = '0;
    logic [3:0] held_hu = '0;
    logic [2:0] held_mt = '0;
    logic [3:0] held_mu = '0;
    logic [2:0] held_st = '0;
    logic [3:0] held_su = '0;
    bit         held_running = 1'b0;

    bcd_time_of_day_clock uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic out_item_t face(int ht, int hu, int mt, int mu, int st, int su);
        out_item_t f;
        f.hour_tens    = 2'(ht);
        f.hour_units   = 4'(hu);
        f.minute_tens  = 3'(mt);
        f.minute_units = 4'(mu);
        f.second_tens  = 3'(st);
        f.second_units = 4'(su);
        return f;
    endfunction

    function automatic step_row_t row(mode_t m, logic [23:0] digits, bit typed, bit gives,
                                      out_item_t want);
        step_row_t r;
        r.cmd   = in_item_t'({m, digits});
        r.typed = typed;
        r.gives = gives;
        r.want  = want;
        return r;
    endfunction

    function automatic string show(out_item_t f);
        return $sformatf("%0d%0d:%0d%0d:%0d%0d", f.hour_tens, f.hour_units, f.minute_tens,
                         f.minute_units, f.second_tens, f.second_units);
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function automatic bit pair_fits(logic [3:0] t, logic [3:0] u, int top);
        return t <= MAX_UNITS && u <= MAX_UNITS && int'(t) * 10 + int'(u) <= top;
    endfunction

    // set digits: often parked just ahead of a carry, some out of range or not bcd
    function automatic logic [23:0] random_digits();
        int r;
        int hh;
        int mm;
        int ss;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 24'($urandom);
        if (r < 25)
            return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                    4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                    4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        hh = $urandom_range(0, TOP_HOURS);
        mm = $urandom_range(0, TOP_MINSEC);
        ss = $urandom_range(0, TOP_MINSEC);
        if (r < 65)
        begin
            case ($urandom_range(0, 3))
                0: hh = 9;
                1: hh = 19;
                2: hh = 23;
                default: ;
            endcase
            if ($urandom_range(0, 3) != 0)
                mm = 59;
            ss = $urandom_range(50, 59);
        end
        return {4'(hh / 10), 4'(hh % 10), 4'(mm / 10), 4'(mm % 10), 4'(ss / 10), 4'(ss % 10)};
    endfunction

    task automatic run_command(input in_item_t c, output bit gives, output out_item_t f);
        gives = 1'b1;
        case (c.mode)
            MODE_RESET:
            begin
                {held_ht, held_hu, held_mt, held_mu, held_st, held_su} = '0;
                held_running = 1'b1;
            end
            MODE_SET:
            begin
                if (pair_fits(c.set_hour_tens, c.set_hour_units, TOP_HOURS))
                begin
                    held_ht = c.set_hour_tens[1:0];
                    held_hu = c.set_hour_units;
                end
                else
                begin
                    {held_ht, held_hu} = '0;
                    n_cleared++;
                end
                if (pair_fits(c.set_minute_tens, c.set_minute_units, TOP_MINSEC))
                begin
                    held_mt = c.set_minute_tens[2:0];
                    held_mu = c.set_minute_units;
                end
                else
                begin
                    {held_mt, held_mu} = '0;
                    n_cleared++;
                end
                if (pair_fits(c.set_second_tens, c.set_second_units, TOP_MINSEC))
                begin
                    held_st = c.set_second_tens[2:0];
                    held_su = c.set_second_units;
                end
                else
                begin
                    {held_st, held_su} = '0;
                    n_cleared++;
                end
                held_running = 1'b1;
            end
            MODE_STOP:
            begin
                held_running = 1'b0;
                gives = 1'b0;
            end
            default:
            begin
                if (!held_running)
                    gives = 1'b0;
                else if (held_su != MAX_UNITS)
                    held_su++;
                else
                begin
                    held_su = '0;
                    if (held_st != MAX_MINSEC_TENS)
                        held_st++;
                    else
                    begin
                        held_st = '0;
                        if (held_mu != MAX_UNITS)
                            held_mu++;
                        else
                        begin
                            held_mu = '0;
                            if (held_mt != MAX_MINSEC_TENS)
                                held_mt++;
                            else
                            begin
                                held_mt = '0;
                                if (held_ht == MAX_HOUR_TENS && held_hu == MAX_HOUR_UNITS_AT_TOP)
                                begin
                                    {held_ht, held_hu} = '0;
                                    n_wraps++;
                                end
                                else if (held_hu == MAX_UNITS)
                                begin
                                    held_hu = '0;
                                    held_ht++;
                                end
                                else
                                    held_hu++;
                            end
                        end
                    end
                end
            end
        endcase
        f.hour_tens    = held_ht;
        f.hour_units   = held_hu;
        f.minute_tens  = held_mt;
        f.minute_units = held_mu;
        f.second_tens  = held_st;
        f.second_units = held_su;
    endtask

    task automatic send_item(input in_item_t c, input bit typed, input bit gives,
                             input out_item_t want);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_item   <= c;
        row_typed <= typed;
        row_gives <= gives;
        row_want  <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // hold off until every predicted time has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_faces.size() != 0);
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t predicted;
        bit        gives;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (pending_faces.size() == 0)
                    note_failure($sformatf("result %s with nothing expected", show(out_item)));
                else
                begin
                    want = pending_faces.pop_front();
                    if (out_item !== want)
                        note_failure($sformatf("expected %s, got %s", show(want),
                                               show(out_item)));
                end
            end
            if (in_valid && in_ready)
            begin
                run_command(in_item, gives, predicted);
                if (row_typed)
                begin
                    gives     = row_gives;
                    predicted = row_want;
                end
                if (gives)
                    pending_faces.push_back(predicted);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else if (++idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_faces.size());
                $display("[bcd_time_of_day_clock] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        step_row_t plan[$];
        in_item_t  cmd;
        mode_t     m;
        int        r;
        int        useful;
        int        segment;
        bit        sent_running;

        plan = '{
            row(MODE_TICK,  24'h000000, 1, 0, '0),                   // stopped after reset
            row(MODE_STOP,  24'h000000, 1, 0, '0),
            row(MODE_RESET, 24'h000000, 1, 1, face(0, 0, 0, 0, 0, 0)),
            row(MODE_TICK,  24'h000000, 1, 1, face(0, 0, 0, 0, 0, 1)),
            row(MODE_SET,   24'h235959, 1, 1, face(2, 3, 5, 9, 5, 9)),
            row(MODE_TICK,  24'h000000, 1, 1, face(0, 0, 0, 0, 0, 0)), // midnight wrap
            row(MODE_SET,   24'h095959, 0, 0, '0),
            row(MODE_TICK,  24'h000000, 0, 0, '0),
            row(MODE_SET,   24'h195959, 0, 0, '0),
            row(MODE_TICK,  24'h000000, 0, 0, '0),
            row(MODE_SET,   24'h243015, 1, 1, face(0, 0, 3, 0, 1, 5)),
            row(MODE_SET,   24'h126030, 1, 1, face(1, 2, 0, 0, 3, 0)),
            row(MODE_SET,   24'h123460, 1, 1, face(1, 2, 3, 4, 0, 0)),
            row(MODE_SET,   24'h999999, 1, 1, face(0, 0, 0, 0, 0, 0)),
            row(MODE_SET,   24'hFFFFFF, 1, 1, face(0, 0, 0, 0, 0, 0)),
            row(MODE_SET,   24'h1A595B, 1, 1, face(0, 0, 5, 9, 0, 0)), // non-bcd digits
            row(MODE_STOP,  24'hFFFFFF, 1, 0, '0),
            row(MODE_TICK,  24'h000000, 1, 0, '0),
            row(MODE_TICK,  24'hFFFFFF, 1, 0, '0),
            row(MODE_SET,   24'h123456, 1, 1, face(1, 2, 3, 4, 5, 6)), // restarts from stop
            row(MODE_TICK,  24'hABCDEF, 0, 0, '0),
            row(MODE_RESET, 24'h235959, 1, 1, face(0, 0, 0, 0, 0, 0)), // digits ignored
            row(MODE_TICK,  24'h000000, 1, 1, face(0, 0, 0, 0, 0, 1)),
            row(MODE_SET,   24'h000959, 0, 0, '0),
            row(MODE_TICK,  24'h000000, 0, 0, '0)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct   = 25;
        stall_pct = 25;
        foreach (plan[i])
            send_item(plan[i].cmd, plan[i].typed, plan[i].gives, plan[i].want);
        drain();

        sent_running = held_running;
        useful  = 0;
        segment = -1;
        while (useful < RANDOM_ITEMS)
        begin
            if (useful >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (useful / 100 != segment)
            begin
                segment = useful / 100;
                gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            end
            r = $urandom_range(0, 99);
            if (r < 72)
                m = MODE_TICK;
            else if (r < 86)
                m = MODE_SET;
            else if (r < 92)
                m = MODE_RESET;
            else
                m = MODE_STOP;
            cmd = in_item_t'({m, (m == MODE_SET) ? random_digits() : 24'($urandom)});
            send_item(cmd, 1'b0, 1'b0, '0);
            // ticks and stops on a stopped clock do nothing
            if (sent_running || m == MODE_RESET || m == MODE_SET)
            begin
                useful++;
                if (useful % DRAIN_EVERY == 0)
                    drain();
            end
            sent_running = (m == MODE_STOP) ? 1'b0 :
                           (m == MODE_TICK) ? sent_running : 1'b1;
        end

        drain();
        repeat (8) @(posedge clk);
        if (pending_faces.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_faces.size()));

        $display("directed table of %0d commands, then %0d random commands that moved the clock",
                 plan.size(), useful);
        $display("%0d displayed times checked, %0d midnight wraps, %0d set pairs cleared,",
                 n_results, n_wraps, n_cleared);
        $display("%0d failures", fail_count);
        if (fail_count == 0)
            $display("[bcd_time_of_day_clock] OK");
        else
            $display("[bcd_time_of_day_clock] ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/btod_pkg.sv
src/bcd_time_of_day_clock.sv
dv/tb.sv
